>>> hw/rtl/assert_macros.svh
// assertion macros shared by the pressure compensation rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_ON(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/psc_pkg.sv
// types, widths and constants for the pressure compensation pipeline
`default_nettype none

package psc_pkg;

    localparam int RAW_W      = 24;
    localparam int CAL_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int TEMP_OUT_W = 19;
    localparam int PRES_OUT_W = 32;

    localparam int TDIFF_W    = RAW_W + 1;
    localparam int PROD1_W    = TDIFF_W + CAL_W + 1;
    localparam int SQ_T_W     = 2 * TDIFF_W;
    localparam int DEV_W      = 19;
    localparam int T1_W       = DEV_W + 1;
    localparam int T2_W       = T1_W + 1;
    localparam int OFF1_W     = 36;
    localparam int SENS1_W    = 35;
    localparam int TCORR_W    = 18;
    localparam int DSQ_W      = 2 * DEV_W;
    localparam int VDEV_W     = DEV_W + 1;
    localparam int VSQ_W      = 2 * VDEV_W;
    localparam int CORR_W     = 44;
    localparam int OFF2_W     = CORR_W + 1;
    localparam int SENS2_W    = CORR_W + 1;
    localparam int SPLIT_LO_W = 22;
    localparam int SPLIT_HI_W = SENS2_W - SPLIT_LO_W;
    localparam int PP_W       = RAW_W + SPLIT_HI_W + 1;
    localparam int PROD_W     = PP_W + SPLIT_LO_W;

    localparam int T_SHIFT    = 23;
    localparam int OFF_SHIFT  = 7;
    localparam int SENS_SHIFT = 8;
    localparam int TLO_SHIFT  = 33;
    localparam int THI_SHIFT  = 36;
    localparam int P1_SHIFT   = 21;
    localparam int P2_SHIFT   = 13;
    localparam int OFF_SCALE  = 16;
    localparam int SENS_SCALE = 15;

    localparam int PD_W       = PROD_W - P1_SHIFT;
    localparam int PA_W       = PD_W + 1;
    localparam int PQ_W       = PA_W - P2_SHIFT;

    localparam int TEMP_BASE     = 2000;
    localparam int TEMP_VERY_LOW = -1500;
    localparam int VERY_LOW_DEV  = TEMP_VERY_LOW - TEMP_BASE;

    localparam logic signed [PRES_OUT_W-1:0] PRES_MAX = {1'b0, {(PRES_OUT_W-1){1'b1}}};
    localparam logic signed [PRES_OUT_W-1:0] PRES_MIN = {1'b1, {(PRES_OUT_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESSURE_SENSITIVITY   = 3'd0,
        CFG_PRESSURE_OFFSET        = 3'd1,
        CFG_SENSITIVITY_TEMP_COEFF = 3'd2,
        CFG_OFFSET_TEMP_COEFF      = 3'd3,
        CFG_REFERENCE_TEMPERATURE  = 3'd4,
        CFG_TEMPERATURE_COEFF      = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [CAL_W-1:0] pressure_sensitivity;
        logic [CAL_W-1:0] pressure_offset;
        logic [CAL_W-1:0] sensitivity_temp_coeff;
        logic [CAL_W-1:0] offset_temp_coeff;
        logic [CAL_W-1:0] reference_temperature;
        logic [CAL_W-1:0] temperature_coeff;
    } cal_t;

    typedef struct packed {
        logic [RAW_W-1:0] pressure_raw;
        logic [RAW_W-1:0] temperature_raw;
    } in_item_t;

    typedef struct packed {
        logic signed [TEMP_OUT_W-1:0] temperature_centi;
        logic signed [PRES_OUT_W-1:0] pressure_tenth_mbar;
    } out_item_t;

    typedef struct packed {
        logic [RAW_W-1:0]          pressure_raw;
        logic signed [DEV_W-1:0]   dev;
        logic signed [OFF1_W-1:0]  offset1;
        logic signed [SENS1_W-1:0] sensit1;
        logic [TCORR_W-1:0]        tcorr_lo;
        logic [TCORR_W-1:0]        tcorr_hi;
    } fo_t;

    typedef struct packed {
        logic [RAW_W-1:0]             pressure_raw;
        logic signed [TEMP_OUT_W-1:0] temperature_centi;
        logic signed [OFF2_W-1:0]     offset2;
        logic signed [SENS2_W-1:0]    sensit2;
    } so_t;

endpackage

`default_nettype wire

>>> hw/rtl/psc_first_order.sv
// first-order stages: dT, calibration products, truncated scaling
`default_nettype none

`include "assert_macros.svh"

module psc_first_order
    import psc_pkg::*;
(
    input  wire             clk,
    input  wire             rst_n,
    input  wire cal_t       cal,
    input  wire             in_valid,
    output logic            in_ready,
    input  wire in_item_t   in_item,
    output logic            out_valid,
    input  wire             out_ready,
    output fo_t             out_item
);

    localparam int NSTG = 3;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] adv;

    always_comb
    begin
        adv[NSTG-1] = !vld_reg[NSTG-1] || out_ready;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign vld_next = (adv & {vld_reg[NSTG-2:0], in_valid}) | (~adv & vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[NSTG-1];

    // stage 1: dT
    logic [RAW_W-1:0]          d1_s1_reg;
    logic signed [TDIFF_W-1:0] tdiff_s1_reg;
    logic signed [TDIFF_W-1:0] tdiff_next;

    assign tdiff_next = $signed({1'b0, in_item.temperature_raw})
                      - $signed({1'b0, cal.reference_temperature, 8'h00});

    // stage 2: products
    logic [RAW_W-1:0]          d1_s2_reg;
    logic signed [PROD1_W-1:0] p6_reg, p4_reg, p3_reg;
    logic signed [PROD1_W-1:0] p6_next, p4_next, p3_next;
    logic signed [SQ_T_W-1:0]  psq_reg;
    logic signed [SQ_T_W-1:0]  psq_next;

    assign p6_next  = PROD1_W'(tdiff_s1_reg)
                    * PROD1_W'($signed({1'b0, cal.temperature_coeff}));
    assign p4_next  = PROD1_W'(tdiff_s1_reg)
                    * PROD1_W'($signed({1'b0, cal.offset_temp_coeff}));
    assign p3_next  = PROD1_W'(tdiff_s1_reg)
                    * PROD1_W'($signed({1'b0, cal.sensitivity_temp_coeff}));
    assign psq_next = SQ_T_W'(tdiff_s1_reg) * SQ_T_W'(tdiff_s1_reg);

    // stage 3: divisions truncating toward zero
    logic [PROD1_W-1:0]  p6_bias, p4_bias, p3_bias;
    logic [SQ_T_W:0]     psq3;
    fo_t                 fo_reg;
    fo_t                 fo_next;

    assign p6_bias = p6_reg + PROD1_W'({T_SHIFT{p6_reg[PROD1_W-1]}});
    assign p4_bias = p4_reg + PROD1_W'({OFF_SHIFT{p4_reg[PROD1_W-1]}});
    assign p3_bias = p3_reg + PROD1_W'({SENS_SHIFT{p3_reg[PROD1_W-1]}});
    assign psq3    = {psq_reg, 1'b0} + (SQ_T_W+1)'(psq_reg);

    always_comb
    begin
        fo_next.pressure_raw = d1_s2_reg;
        fo_next.dev          = $signed(p6_bias[PROD1_W-1:T_SHIFT]);
        fo_next.offset1      = $signed(OFF1_W'({cal.pressure_offset, {OFF_SCALE{1'b0}}}))
                             + OFF1_W'($signed(p4_bias[PROD1_W-1:OFF_SHIFT]));
        fo_next.sensit1      = $signed(SENS1_W'({cal.pressure_sensitivity,
                                                 {SENS_SCALE{1'b0}}}))
                             + SENS1_W'($signed(p3_bias[PROD1_W-1:SENS_SHIFT]));
        fo_next.tcorr_lo     = TCORR_W'(psq3[SQ_T_W:TLO_SHIFT]);
        fo_next.tcorr_hi     = TCORR_W'(psq_reg[SQ_T_W-1:THI_SHIFT]);
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            d1_s1_reg    <= in_item.pressure_raw;
            tdiff_s1_reg <= tdiff_next;
        end
        if (adv[1])
        begin
            d1_s2_reg <= d1_s1_reg;
            p6_reg    <= p6_next;
            p4_reg    <= p4_next;
            p3_reg    <= p3_next;
            psq_reg   <= psq_next;
        end
        if (adv[2])
        begin
            fo_reg <= fo_next;
        end
    end

    assign out_item = fo_reg;

    `ASSERT_ON(a_fo_hold, clk, rst_n, vld_reg[1] && !adv[1] |=> vld_reg[1], "held item dropped in product stage")

endmodule

`default_nettype wire

>>> hw/rtl/psc_second_order.sv
// second-order stages: squares, branch corrections, corrected offset and sensitivity
`default_nettype none

`include "assert_macros.svh"

module psc_second_order
    import psc_pkg::*;
(
    input  wire             clk,
    input  wire             rst_n,
    input  wire             in_valid,
    output logic            in_ready,
    input  wire fo_t        in_item,
    output logic            out_valid,
    input  wire             out_ready,
    output so_t             out_item
);

    localparam int NSTG = 3;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] adv;

    always_comb
    begin
        adv[NSTG-1] = !vld_reg[NSTG-1] || out_ready;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign vld_next = (adv & {vld_reg[NSTG-2:0], in_valid}) | (~adv & vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[NSTG-1];

    // stage 4: squares and branch flags
    logic [RAW_W-1:0]          d1_s4_reg;
    logic signed [T1_W-1:0]    t1_s4_reg;
    logic [TCORR_W-1:0]        tcorr_s4_reg;
    logic signed [OFF1_W-1:0]  off1_s4_reg;
    logic signed [SENS1_W-1:0] sens1_s4_reg;
    logic signed [DSQ_W-1:0]   dsq_s4_reg;
    logic signed [VSQ_W-1:0]   vsq_s4_reg;
    logic                      low_s4_reg;
    logic                      vlow_s4_reg;

    logic signed [VDEV_W-1:0]  vdev;
    logic signed [T1_W-1:0]    t1_next;
    logic signed [DSQ_W-1:0]   dsq_next;
    logic signed [VSQ_W-1:0]   vsq_next;
    logic                      low_next;
    logic                      vlow_next;
    logic [TCORR_W-1:0]        tcorr_next;

    assign vdev       = VDEV_W'(in_item.dev) - VDEV_W'(VERY_LOW_DEV);
    assign t1_next    = T1_W'(in_item.dev) + T1_W'(TEMP_BASE);
    assign dsq_next   = DSQ_W'(in_item.dev) * DSQ_W'(in_item.dev);
    assign vsq_next   = VSQ_W'(vdev) * VSQ_W'(vdev);
    assign low_next   = in_item.dev[DEV_W-1];
    assign vlow_next  = in_item.dev < VERY_LOW_DEV;
    assign tcorr_next = low_next ? in_item.tcorr_lo : in_item.tcorr_hi;

    // stage 5: offset and sensitivity corrections, final temperature
    logic [RAW_W-1:0]             d1_s5_reg;
    logic signed [TEMP_OUT_W-1:0] temp_s5_reg;
    logic signed [OFF1_W-1:0]     off1_s5_reg;
    logic signed [SENS1_W-1:0]    sens1_s5_reg;
    logic signed [CORR_W-1:0]     offc_s5_reg;
    logic signed [CORR_W-1:0]     sensc_s5_reg;

    logic signed [CORR_W-1:0] dsqx, vsqx;
    logic signed [CORR_W-1:0] offc_next, sensc_next;
    logic [T2_W-1:0]          t2_next;

    assign dsqx    = CORR_W'(dsq_s4_reg);
    assign vsqx    = CORR_W'(vsq_s4_reg);
    assign t2_next = T2_W'(t1_s4_reg) - T2_W'(tcorr_s4_reg);

    always_comb
    begin
        if (low_s4_reg)
        begin
            offc_next  = ((dsqx <<< 1) + dsqx) >>> 1;
            sensc_next = ((dsqx <<< 2) + dsqx) >>> 3;
            if (vlow_s4_reg)
            begin
                offc_next  = offc_next + ((vsqx <<< 3) - vsqx);
                sensc_next = sensc_next + (vsqx <<< 2);
            end
        end
        else
        begin
            offc_next  = dsqx >>> 4;
            sensc_next = '0;
        end
    end

    // stage 6: corrected offset and sensitivity
    so_t so_reg;
    so_t so_next;

    always_comb
    begin
        so_next.pressure_raw      = d1_s5_reg;
        so_next.temperature_centi = temp_s5_reg;
        so_next.offset2           = OFF2_W'(off1_s5_reg) - OFF2_W'(offc_s5_reg);
        so_next.sensit2           = SENS2_W'(sens1_s5_reg) - SENS2_W'(sensc_s5_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            d1_s4_reg    <= in_item.pressure_raw;
            t1_s4_reg    <= t1_next;
            tcorr_s4_reg <= tcorr_next;
            off1_s4_reg  <= in_item.offset1;
            sens1_s4_reg <= in_item.sensit1;
            dsq_s4_reg   <= dsq_next;
            vsq_s4_reg   <= vsq_next;
            low_s4_reg   <= low_next;
            vlow_s4_reg  <= vlow_next;
        end
        if (adv[1])
        begin
            d1_s5_reg    <= d1_s4_reg;
            temp_s5_reg  <= $signed(t2_next[TEMP_OUT_W-1:0]);
            off1_s5_reg  <= off1_s4_reg;
            sens1_s5_reg <= sens1_s4_reg;
            offc_s5_reg  <= offc_next;
            sensc_s5_reg <= sensc_next;
        end
        if (adv[2])
        begin
            so_reg <= so_next;
        end
    end

    assign out_item = so_reg;

    `ASSERT_ON(a_so_branch, clk, rst_n, vld_reg[0] && vlow_s4_reg |-> low_s4_reg, "very low branch taken outside low branch")

endmodule

`default_nettype wire

>>> hw/rtl/psc_pressure.sv
// pressure stages: split wide product, truncated scaling, saturation, output register
`default_nettype none

`include "assert_macros.svh"

module psc_pressure
    import psc_pkg::*;
(
    input  wire             clk,
    input  wire             rst_n,
    input  wire             in_valid,
    output logic            in_ready,
    input  wire so_t        in_item,
    output logic            out_valid,
    input  wire             out_ready,
    output out_item_t       out_item
);

    localparam int NSTG = 5;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] adv;

    always_comb
    begin
        adv[NSTG-1] = !vld_reg[NSTG-1] || out_ready;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign vld_next = (adv & {vld_reg[NSTG-2:0], in_valid}) | (~adv & vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[NSTG-1];

    // stage 7: partial products of D1 and SENS2
    logic signed [PP_W-1:0]       pp_lo_reg, pp_hi_reg;
    logic signed [PP_W-1:0]       pp_lo_next, pp_hi_next;
    logic signed [OFF2_W-1:0]     off2_s7_reg;
    logic signed [TEMP_OUT_W-1:0] temp_s7_reg;
    logic signed [RAW_W:0]        d1s;

    assign d1s        = $signed({1'b0, in_item.pressure_raw});
    assign pp_lo_next = PP_W'(d1s)
                      * PP_W'($signed({1'b0, in_item.sensit2[SPLIT_LO_W-1:0]}));
    assign pp_hi_next = PP_W'(d1s)
                      * PP_W'($signed(in_item.sensit2[SENS2_W-1:SPLIT_LO_W]));

    // stage 8: full product
    logic signed [PROD_W-1:0]     prod_reg;
    logic signed [PROD_W-1:0]     prod_next;
    logic signed [OFF2_W-1:0]     off2_s8_reg;
    logic signed [TEMP_OUT_W-1:0] temp_s8_reg;

    assign prod_next = (PROD_W'(pp_hi_reg) <<< SPLIT_LO_W) + PROD_W'(pp_lo_reg);

    // stage 9: product over 2^21
    logic signed [PD_W-1:0]       pd_reg;
    logic [PROD_W-1:0]            prod_bias;
    logic signed [OFF2_W-1:0]     off2_s9_reg;
    logic signed [TEMP_OUT_W-1:0] temp_s9_reg;

    assign prod_bias = prod_reg + PROD_W'({P1_SHIFT{prod_reg[PROD_W-1]}});

    // stage 10: minus OFF2
    logic signed [PA_W-1:0]       pa_reg;
    logic signed [PA_W-1:0]       pa_next;
    logic signed [TEMP_OUT_W-1:0] temp_s10_reg;

    assign pa_next = PA_W'(pd_reg) - PA_W'(off2_s9_reg);

    // stage 11: over 2^13 and saturate
    logic [PA_W-1:0]              pa_bias;
    logic [PQ_W-1:0]              pq;
    logic                         ovf;
    out_item_t                    out_reg;
    out_item_t                    out_next;

    assign pa_bias = pa_reg + PA_W'({P2_SHIFT{pa_reg[PA_W-1]}});
    assign pq      = pa_bias[PA_W-1:P2_SHIFT];
    assign ovf     = pq[PQ_W-1:PRES_OUT_W-1] != {(PQ_W-PRES_OUT_W+1){pq[PQ_W-1]}};

    always_comb
    begin
        out_next.temperature_centi = temp_s10_reg;
        if (ovf)
        begin
            out_next.pressure_tenth_mbar = pq[PQ_W-1] ? PRES_MIN : PRES_MAX;
        end
        else
        begin
            out_next.pressure_tenth_mbar = $signed(pq[PRES_OUT_W-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            pp_lo_reg   <= pp_lo_next;
            pp_hi_reg   <= pp_hi_next;
            off2_s7_reg <= in_item.offset2;
            temp_s7_reg <= in_item.temperature_centi;
        end
        if (adv[1])
        begin
            prod_reg    <= prod_next;
            off2_s8_reg <= off2_s7_reg;
            temp_s8_reg <= temp_s7_reg;
        end
        if (adv[2])
        begin
            pd_reg      <= $signed(prod_bias[PROD_W-1:P1_SHIFT]);
            off2_s9_reg <= off2_s8_reg;
            temp_s9_reg <= temp_s8_reg;
        end
        if (adv[3])
        begin
            pa_reg       <= pa_next;
            temp_s10_reg <= temp_s9_reg;
        end
        if (adv[4])
        begin
            out_reg <= out_next;
        end
    end

    assign out_item = out_reg;

    `ASSERT_ON(a_pr_empty_ready, clk, rst_n, !vld_reg[NSTG-1] |-> in_ready, "input blocked with empty output register")
    `ASSERT_ALWAYS(a_pr_reset_idle, clk, !rst_n |-> !out_valid, "result shown during reset")

endmodule

`default_nettype wire

>>> hw/rtl/pressure_sensor_compensation.sv
// top level: calibration registers and the three pipeline sections
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes one of the six
//   16-bit calibration words C1..C6 at index 0..5; cfg_ready is always high and
//   writes to index 6 or 7 are dropped. Write calibration while no item is in flight.
//   in channel (in_valid/in_stall, in_item) takes raw pressure D1 and temperature D2;
//   an item is taken at an edge with in_valid high and in_stall low.
//   out channel (out_valid/out_stall, out_item) returns temperature in hundredths of
//   a degree and saturated pressure in tenths of a millibar, one result per item.
// Each item passes through the eleven-stage pipeline (dT, products, scaling,
// squares, corrections, differences, partial products, product merge, scaling by
// 2^21, offset subtraction, final scaling with saturation); throughput is one item
// per cycle while out_stall is low.
// Reset clears every stage valid bit and all calibration words to zero.
// While out_stall is high the output register holds its item; earlier stages keep
// filling empty slots, and in_stall rises once every stage holds an item.
`default_nettype none

module pressure_sensor_compensation
    import psc_pkg::*;
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire [CFG_IDX_W-1:0]  cfg_index,
    input  wire [CAL_W-1:0]      cfg_data,
    input  wire                  in_valid,
    output logic                 in_stall,
    input  wire in_item_t        in_item,
    output logic                 out_valid,
    input  wire                  out_stall,
    output out_item_t            out_item
);

    cal_t cal_reg;
    cal_t cal_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cal_next = cal_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PRESSURE_SENSITIVITY:   cal_next.pressure_sensitivity   = cfg_data;
                CFG_PRESSURE_OFFSET:        cal_next.pressure_offset        = cfg_data;
                CFG_SENSITIVITY_TEMP_COEFF: cal_next.sensitivity_temp_coeff = cfg_data;
                CFG_OFFSET_TEMP_COEFF:      cal_next.offset_temp_coeff      = cfg_data;
                CFG_REFERENCE_TEMPERATURE:  cal_next.reference_temperature  = cfg_data;
                CFG_TEMPERATURE_COEFF:      cal_next.temperature_coeff      = cfg_data;
                default:                    cal_next = cal_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= '0;
        end
        else
        begin
            cal_reg <= cal_next;
        end
    end

    logic in_ready;
    logic fo_valid, fo_ready;
    fo_t  fo_item;
    logic so_valid, so_ready;
    so_t  so_item;

    assign in_stall = !in_ready;

    psc_first_order u_first_order (
        .clk       (clk),
        .rst_n     (rst_n),
        .cal       (cal_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (fo_valid),
        .out_ready (fo_ready),
        .out_item  (fo_item)
    );

    psc_second_order u_second_order (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fo_valid),
        .in_ready  (fo_ready),
        .in_item   (fo_item),
        .out_valid (so_valid),
        .out_ready (so_ready),
        .out_item  (so_item)
    );

    psc_pressure u_pressure (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (so_valid),
        .in_ready  (so_ready),
        .in_item   (so_item),
        .out_valid (out_valid),
        .out_ready (!out_stall),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire
